// ===== rtl/pcta_pkg.sv =====
// Package for the pairwise charge transfer block: field widths, rule layout,
// taper polynomial coefficients, register indexes and the sequencer states.
// No dependencies.
`default_nettype none
package pcta_pkg;

  localparam int ATOM_COUNT_DEF = 1024;
  localparam int RULE_SLOTS_DEF = 4;
  localparam int WORD_COUNT     = 4;

  localparam int IDX_W      = 10;
  localparam int CHG_W      = 16;
  localparam int DELTA_W    = 16;
  localparam int TYPE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_WORD0 = 3'd1;

  // cosine taper polynomial in Q30
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic signed [33:0] COEF_A  = 34'sd1324675879;
  localparam logic signed [33:0] COEF_B  = 34'sd272375560;
  localparam logic signed [33:0] COEF_C  = 34'sd22401992;
  localparam logic signed [33:0] COEF_D  = 34'sd987048;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_RSQ,
    S_SQRT,
    S_RULE,
    S_CHECK,
    S_DIV,
    S_W,
    S_POLY,
    S_F,
    S_MAG,
    S_ADD,
    S_DONE
  } pcta_state_t;

  // polynomial constant for Horner step k
  function automatic logic signed [33:0] poly_coef(input logic [1:0] k);
    logic signed [33:0] c;
    case (k)
      2'd0:    c = COEF_C;
      2'd1:    c = COEF_B;
      2'd2:    c = COEF_A;
      default: c = Q30_ONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pcta_in_if.sv =====
// Request channel of the pairwise charge transfer block: valid/ready plus
// the request fields. Depends on pcta_pkg.
`default_nettype none
interface pcta_in_if;
  import pcta_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [IDX_W-1:0]          atom_index;
  logic signed [CHG_W-1:0]   charge_in;
  logic [TYPE_W-1:0]         type_first;
  logic [TYPE_W-1:0]         type_second;
  logic                      same_molecule;
  logic                      group_first;
  logic                      group_second;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic signed [DELTA_W-1:0] delta_z;

  modport source (output valid, op, atom_index, charge_in, type_first, type_second,
                  same_molecule, group_first, group_second, delta_x, delta_y, delta_z,
                  input ready);
  modport sink (input valid, op, atom_index, charge_in, type_first, type_second,
                same_molecule, group_first, group_second, delta_x, delta_y, delta_z,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/pcta_out_if.sv =====
// Result channel of the pairwise charge transfer block: valid/ready plus
// the reported atom and charge. Depends on pcta_pkg.
`default_nettype none
interface pcta_out_if;
  import pcta_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        atom_out;
  logic signed [CHG_W-1:0] charge_out;

  modport source (output valid, atom_out, charge_out, input ready);
  modport sink (input valid, atom_out, charge_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/pairwise_charge_transfer_accumulate.sv =====
// Per-atom charge store with pairwise charge transfer. One request at a time:
// a load or an out-of-range index goes straight to the output register, a
// skipped pair after the charge read, and an applied pair after the 16-step
// square root and the rule loop, where a tapered rule also runs the 17-step
// divider and the 4-step taper polynomial.
// Charges sit in a one-port synchronous RAM (read at accept, written at the
// end of the request). Entries read before being loaded hold no defined value.
// Depends on pcta_pkg, pcta_in_if and pcta_out_if.
`default_nettype none
module pairwise_charge_transfer_accumulate #(
  parameter int ATOM_COUNT = pcta_pkg::ATOM_COUNT_DEF,
  parameter int RULE_SLOTS = pcta_pkg::RULE_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pcta_in_if.sink                             in_req,
  pcta_out_if.source                          out_rsp,
  input  logic                                cfg_we,
  input  logic [pcta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcta_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pcta_pkg::*;

  localparam int AW         = $clog2(ATOM_COUNT);
  localparam int RULE_WORDS = (RULE_SLOTS < WORD_COUNT) ? RULE_SLOTS : WORD_COUNT;
  localparam int RIW        = (RULE_WORDS > 1) ? $clog2(RULE_WORDS) : 1;

  // configuration
  logic [CFG_IDX_W-1:0]  rule_count_r;
  logic [CFG_DATA_W-1:0] rule_r [RULE_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
      for (int i = 0; i < RULE_WORDS; i++) rule_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RULE_COUNT) rule_count_r <= cfg_data[CFG_IDX_W-1:0];
      for (int i = 0; i < RULE_WORDS; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_RULE_WORD0) + i)) rule_r[i] <= cfg_data;
      end
    end
  end

  // sequencer state
  pcta_state_t state_r, state_nxt;

  logic                    in_fire;
  logic                    out_free;
  logic [AW-1:0]           addr_in;
  logic                    in_range;
  logic [IDX_W-1:0]        idx_r;
  logic [AW-1:0]           addr_r;
  logic                    skip_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r, dz_r;
  logic [TYPE_W-1:0]       ti_r, tj_r;
  logic [1:0]              axis_r;
  logic [31:0]             rsq_r;
  logic [31:0]             sq_src_r;
  logic [17:0]             sq_rem_r;
  logic [15:0]             root_r;
  logic [4:0]              cnt_r;
  logic [CFG_IDX_W-1:0]    m_r, n_r;
  logic [31:0]             rcsq_r;
  logic                    match_r, fwd_r;
  logic [16:0]             dv_rem_r;
  logic [16:0]             u_r;
  logic [16:0]             w_r;
  logic signed [33:0]      p_r;
  logic [1:0]              k_r;
  logic [30:0]             f_r;
  logic signed [17:0]      inc_r;
  logic signed [CHG_W-1:0] q_r;
  logic signed [CHG_W-1:0] res_r;
  logic                    wr_r;

  // memory
  logic signed [CHG_W-1:0] mem [ATOM_COUNT];
  logic signed [CHG_W-1:0] rd_q_r;

  // out register
  logic                    out_valid_r;
  logic [IDX_W-1:0]        atom_out_r;
  logic signed [CHG_W-1:0] charge_out_r;

  assign in_req.ready       = (state_r == S_IDLE);
  assign in_fire            = in_req.valid && in_req.ready;
  assign out_free           = !out_valid_r || out_rsp.ready;
  assign addr_in            = AW'(in_req.atom_index);
  assign in_range           = ({22'd0, in_req.atom_index} < 32'(ATOM_COUNT));
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.atom_out   = atom_out_r;
  assign out_rsp.charge_out = charge_out_r;

  // current rule fields
  logic [CFG_DATA_W-1:0]   rw;
  logic [TYPE_W-1:0]       t1, t2;
  logic signed [CHG_W-1:0] dq;
  logic [15:0]             rc, sg;
  logic                    last_rule;

  assign rw        = rule_r[m_r[RIW-1:0]];
  assign t1        = rw[3:0];
  assign t2        = rw[7:4];
  assign dq        = $signed(rw[23:8]);
  assign rc        = rw[39:24];
  assign sg        = rw[55:40];
  assign last_rule = (m_r + 3'd1 == n_r);

  // datapath terms
  logic signed [DELTA_W-1:0] dsel;
  logic [31:0]             dsq;
  logic [31:0]             rsq_sum;
  logic [19:0]             sq_sh, sq_trial;
  logic                    sq_ge;
  logic [17:0]             rsg, tval;
  logic                    taper;
  logic [17:0]             dv_trial;
  logic                    dv_ge;
  logic [33:0]             usq;
  logic signed [51:0]      pw;
  logic [30:0]             pc;
  logic [61:0]             psq;
  logic [16:0]             absdq;
  logic [47:0]             magp;
  logic [17:0]             mag;
  logic signed [19:0]      qsum;
  logic signed [CHG_W-1:0] qsat;

  always_comb begin
    case (axis_r)
      2'd0:    dsel = dx_r;
      2'd1:    dsel = dy_r;
      default: dsel = dz_r;
    endcase
    dsq      = 32'(dsel * dsel);
    rsq_sum  = rsq_r + dsq;
    sq_sh    = {sq_rem_r, sq_src_r[31:30]};
    sq_trial = {2'd0, root_r, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    rsg      = {2'd0, root_r} + {2'd0, sg};
    tval     = rsg - {2'd0, rc};
    taper    = (sg != 16'd0) && (rsg > {2'd0, rc});
    dv_trial = (cnt_r == 5'd0) ? {1'b0, dv_rem_r} : {dv_rem_r, 1'b0};
    dv_ge    = (dv_trial >= {2'd0, sg});
    usq      = u_r * u_r;
    pw       = p_r * $signed({1'b0, w_r});
    pc       = p_r[33] ? 31'd0 : p_r[30:0];
    psq      = pc * pc;
    absdq    = dq[CHG_W-1] ? 17'(-{dq[CHG_W-1], dq}) : {1'b0, dq};
    magp     = (absdq * f_r) + 48'd536870912;
    mag      = magp[47:30];
    qsum     = 20'(q_r) + (fwd_r ? 20'(inc_r) : -20'(inc_r));
    if (qsum > 20'sd32767)       qsat = 16'sh7FFF;
    else if (qsum < -20'sd32768) qsat = 16'sh8000;
    else                         qsat = qsum[CHG_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_range || !in_req.op) state_nxt = S_DONE;
          else                         state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = skip_r ? S_DONE : S_RSQ;
      S_RSQ:   if (axis_r == 2'd2) state_nxt = S_SQRT;
      S_SQRT:  if (cnt_r == 5'd15) state_nxt = (n_r == '0) ? S_DONE : S_RULE;
      S_RULE:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (rsq_r > rcsq_r || !match_r) state_nxt = last_rule ? S_DONE : S_RULE;
        else if (taper)                 state_nxt = S_DIV;
        else                            state_nxt = S_ADD;
      end
      S_DIV:   if (cnt_r == 5'd16) state_nxt = S_W;
      S_W:     state_nxt = S_POLY;
      S_POLY:  if (k_r == 2'd3) state_nxt = S_F;
      S_F:     state_nxt = S_MAG;
      S_MAG:   state_nxt = S_ADD;
      S_ADD:   state_nxt = last_rule ? S_DONE : S_RULE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_r  <= in_req.atom_index;
          addr_r <= addr_in;
          skip_r <= !in_req.group_first || !in_req.group_second || in_req.same_molecule;
          dx_r   <= in_req.delta_x;
          dy_r   <= in_req.delta_y;
          dz_r   <= in_req.delta_z;
          ti_r   <= in_req.type_first;
          tj_r   <= in_req.type_second;
          n_r    <= (32'(rule_count_r) > RULE_WORDS) ? CFG_IDX_W'(RULE_WORDS)
                                                    : rule_count_r;
          res_r  <= in_range ? in_req.charge_in : '0;
          wr_r   <= in_range;
          axis_r <= '0;
          rsq_r  <= '0;
        end
      end
      S_READ: begin
        q_r   <= rd_q_r;
        res_r <= rd_q_r;
        wr_r  <= 1'b0;
      end
      S_RSQ: begin
        rsq_r  <= rsq_sum;
        axis_r <= axis_r + 2'd1;
        if (axis_r == 2'd2) begin
          sq_src_r <= rsq_sum;
          sq_rem_r <= '0;
          root_r   <= '0;
          cnt_r    <= '0;
          m_r      <= '0;
        end
      end
      S_SQRT: begin
        // one result bit per cycle
        sq_src_r <= {sq_src_r[29:0], 2'b00};
        sq_rem_r <= sq_ge ? 18'(sq_sh - sq_trial) : sq_sh[17:0];
        root_r   <= {root_r[14:0], sq_ge};
        cnt_r    <= cnt_r + 5'd1;
        res_r    <= q_r;
        wr_r     <= 1'b1;
      end
      S_RULE: begin
        rcsq_r  <= rc * rc;
        fwd_r   <= (ti_r == t1) && (tj_r == t2);
        match_r <= ((ti_r == t1) && (tj_r == t2)) || ((ti_r == t2) && (tj_r == t1));
      end
      S_CHECK: begin
        res_r    <= q_r;
        inc_r    <= 18'(dq);
        dv_rem_r <= tval[16:0];
        u_r      <= '0;
        cnt_r    <= '0;
        if ((rsq_r > rcsq_r || !match_r) && !last_rule) m_r <= m_r + 3'd1;
      end
      S_DIV: begin
        // one quotient bit per cycle
        dv_rem_r <= dv_ge ? 17'(dv_trial - {2'd0, sg}) : dv_trial[16:0];
        u_r      <= {u_r[15:0], dv_ge};
        cnt_r    <= cnt_r + 5'd1;
      end
      S_W: begin
        w_r <= (u_r > 17'd65536) ? 17'd65536 : usq[32:16];
        if (u_r > 17'd65536) u_r <= 17'd65536;
        p_r <= COEF_D;
        k_r <= '0;
      end
      S_POLY: begin
        p_r <= poly_coef(k_r) - 34'(pw >>> 16);
        k_r <= k_r + 2'd1;
      end
      S_F: f_r <= psq[60:30];
      S_MAG: inc_r <= dq[CHG_W-1] ? -mag : mag;
      S_ADD: begin
        q_r   <= qsat;
        res_r <= qsat;
        if (!last_rule) m_r <= m_r + 3'd1;
      end
      default: ;
    endcase
  end

  // charge memory: read at accept, write back on completion
  always_ff @(posedge clk) begin
    if (in_fire) rd_q_r <= mem[addr_in];
    if (state_r == S_DONE && out_free && wr_r) mem[addr_r] <= res_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      atom_out_r   <= idx_r;
      charge_out_r <= res_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcta_checker.sv =====
// Port-level checks for the pairwise charge transfer block, bound to the top
// level. Depends on pcta_pkg and pairwise_charge_transfer_accumulate.
`default_nettype none
module pcta_checker #(
  parameter int ATOM_COUNT = pcta_pkg::ATOM_COUNT_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pcta_pkg::IDX_W-1:0]        atom_out,
  input logic signed [pcta_pkg::CHG_W-1:0] charge_out
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(atom_out) && $stable(charge_out))
    else $error("stalled result changed");

  // take one request at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // report zero for an index past the store
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ({22'd0, atom_out} >= 32'(ATOM_COUNT)) |-> charge_out == '0)
    else $error("out-of-range atom reported a charge");

  // drop results on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pairwise_charge_transfer_accumulate pcta_checker #(.ATOM_COUNT(ATOM_COUNT)) u_pcta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .atom_out   (out_rsp.atom_out),
  .charge_out (out_rsp.charge_out)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for pairwise_charge_transfer_accumulate: directed and random requests,
// a cycle-free predictor of the charge store, and a result checker.
// Depends on pcta_pkg, pcta_in_if, pcta_out_if and the block itself.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcta_pkg::*;

  localparam int ATOMS      = ATOM_COUNT_DEF;
  localparam int SLOTS      = RULE_SLOTS_DEF;
  localparam int DRAIN_WAIT = 160;

  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          atom;
    logic signed [CHG_W-1:0]   charge;
    logic [TYPE_W-1:0]         ti;
    logic [TYPE_W-1:0]         tj;
    logic                      same_mol;
    logic                      grp_i;
    logic                      grp_j;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dz;
  } charge_req_t;

  typedef struct {
    logic [IDX_W-1:0]        atom;
    logic signed [CHG_W-1:0] charge;
  } charge_rsp_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PAIR = 1'b1;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcta_in_if  in_if ();
  pcta_out_if out_if ();

  pairwise_charge_transfer_accumulate u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if),
    .out_rsp   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow state of the block
  logic signed [CHG_W-1:0] charge_model [ATOMS];
  bit                      loaded [ATOMS];
  int                      loaded_atoms [$];
  logic [2:0]              rule_cnt_model;
  logic [CFG_DATA_W-1:0]   rule_word_model [WORD_COUNT];

  charge_rsp_t expected_charges [$];
  int  fail_count;
  bit  hold_rx;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

  // integer square root, floored
  function automatic longint isqrt_floor(longint v);
    longint res;
    longint b;
    res = 0;
    for (int k = 17; k >= 0; k--) begin
      b = res | (longint'(1) << k);
      if (b * b <= v) res = b;
    end
    return res;
  endfunction

  // cosine-squared taper in Q30 for phase u in Q0.16
  function automatic longint taper_weight(longint u);
    longint w;
    longint p;
    w = (u * u) >>> 16;
    p = longint'(COEF_C) - ((longint'(COEF_D) * w) >>> 16);
    p = longint'(COEF_B) - ((p * w) >>> 16);
    p = longint'(COEF_A) - ((p * w) >>> 16);
    p = longint'(Q30_ONE) - ((p * w) >>> 16);
    if (p < 0) p = 0;
    return (p * p) >>> 30;
  endfunction

  // charge after applying every active rule to one pair
  function automatic logic signed [CHG_W-1:0] transfer_charge(charge_req_t rq,
                                                              logic signed [CHG_W-1:0] q0);
    longint rsq, r, rc, sg, dq, t, u, mag, q;
    int     n, dir;
    logic [CFG_DATA_W-1:0] wv;
    rsq = longint'(rq.dx) * rq.dx + longint'(rq.dy) * rq.dy + longint'(rq.dz) * rq.dz;
    r = isqrt_floor(rsq);
    q = q0;
    n = rule_cnt_model;
    if (n > SLOTS) n = SLOTS;
    if (n > WORD_COUNT) n = WORD_COUNT;
    for (int m = 0; m < n; m++) begin
      wv  = rule_word_model[m];
      dq  = longint'($signed(wv[23:8]));
      rc  = longint'(wv[39:24]);
      sg  = longint'(wv[55:40]);
      dir = 0;
      if (rsq > rc * rc) continue;
      if (rq.ti == wv[3:0] && rq.tj == wv[7:4]) dir = 1;
      else if (rq.ti == wv[7:4] && rq.tj == wv[3:0]) dir = -1;
      if (dir == 0) continue;
      if (sg > 0 && r > rc - sg) begin
        t = r - rc + sg;
        u = (t * 65536) / sg;
        if (u > 65536) u = 65536;
        mag = dq < 0 ? -dq : dq;
        mag = (mag * taper_weight(u) + (longint'(1) << 29)) >>> 30;
        dq  = dq < 0 ? -mag : mag;
      end
      q = q + (dir > 0 ? dq : -dq);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
    end
    return q[CHG_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_rule(int t1, int t2, int dq, int rc, int sg);
    logic [CFG_DATA_W-1:0] w;
    w        = '0;
    w[3:0]   = t1[3:0];
    w[7:4]   = t2[3:0];
    w[23:8]  = dq[15:0];
    w[39:24] = rc[15:0];
    w[55:40] = sg[15:0];
    return w;
  endfunction

  function automatic charge_req_t load_req(int atom, int charge);
    charge_req_t rq;
    rq          = '{default: '0};
    rq.op       = OP_LOAD;
    rq.atom     = atom[IDX_W-1:0];
    rq.charge   = charge[CHG_W-1:0];
    rq.ti       = TYPE_W'($urandom_range(0, 15));
    rq.tj       = TYPE_W'($urandom_range(0, 15));
    rq.same_mol = 1'($urandom_range(0, 1));
    rq.grp_i    = 1'($urandom_range(0, 1));
    rq.grp_j    = 1'($urandom_range(0, 1));
    rq.dx       = DELTA_W'($urandom);
    rq.dy       = DELTA_W'($urandom);
    rq.dz       = DELTA_W'($urandom);
    return rq;
  endfunction

  function automatic charge_req_t pair_req(int atom, int ti, int tj, int dx, int dy, int dz);
    charge_req_t rq;
    rq          = '{default: '0};
    rq.op       = OP_PAIR;
    rq.atom     = atom[IDX_W-1:0];
    rq.charge   = CHG_W'($urandom);
    rq.ti       = ti[3:0];
    rq.tj       = tj[3:0];
    rq.grp_i    = 1'b1;
    rq.grp_j    = 1'b1;
    rq.same_mol = 1'b0;
    rq.dx       = dx[15:0];
    rq.dy       = dy[15:0];
    rq.dz       = dz[15:0];
    return rq;
  endfunction

  // offer one request, hold until accepted, then update the shadow store
  task automatic send_req(charge_req_t rq);
    charge_rsp_t rsp;
    in_if.valid         <= 1'b1;
    in_if.op            <= rq.op;
    in_if.atom_index    <= rq.atom;
    in_if.charge_in     <= rq.charge;
    in_if.type_first    <= rq.ti;
    in_if.type_second   <= rq.tj;
    in_if.same_molecule <= rq.same_mol;
    in_if.group_first   <= rq.grp_i;
    in_if.group_second  <= rq.grp_j;
    in_if.delta_x       <= rq.dx;
    in_if.delta_y       <= rq.dy;
    in_if.delta_z       <= rq.dz;
    do @(posedge clk); while (!in_if.ready);
    if (rq.op == OP_LOAD) begin
      charge_model[rq.atom] = rq.charge;
      if (!loaded[rq.atom]) begin
        loaded[rq.atom] = 1'b1;
        loaded_atoms.push_back(rq.atom);
      end
    end else if (rq.grp_i && rq.grp_j && !rq.same_mol) begin
      charge_model[rq.atom] = transfer_charge(rq, charge_model[rq.atom]);
    end
    rsp.atom   = rq.atom;
    rsp.charge = charge_model[rq.atom];
    expected_charges.push_back(rsp);
  endtask

  // drop valid and idle for a number of cycles
  task automatic idle_tx(int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding response plus the block's latency
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_charges.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RULE_COUNT) rule_cnt_model = data[2:0];
    else rule_word_model[idx - CFG_RULE_WORD0] = data;
  endtask

  task automatic write_rules(int count, logic [CFG_DATA_W-1:0] w0, logic [CFG_DATA_W-1:0] w1,
                             logic [CFG_DATA_W-1:0] w2, logic [CFG_DATA_W-1:0] w3);
    write_reg(CFG_RULE_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_RULE_WORD0,                    w0);
    write_reg(CFG_IDX_W'(CFG_RULE_WORD0 + 3'd1), w1);
    write_reg(CFG_IDX_W'(CFG_RULE_WORD0 + 3'd2), w2);
    write_reg(CFG_IDX_W'(CFG_RULE_WORD0 + 3'd3), w3);
  endtask

  // load extremes of index and charge
  task automatic test_loads();
    send_req(load_req(0, -32768));
    send_req(load_req(1023, 32767));
    send_req(load_req(341, 16'h5555));
    send_req(load_req(682, 0));
    send_req(load_req(7, 32000));
    send_req(load_req(8, -32000));
  endtask

  // pairs skipped by group or molecule flags report the stored charge
  task automatic test_skipped_pairs();
    charge_req_t rq;
    drain();
    write_rules(1, pack_rule(3, 5, 256, 2048, 0), '0, '0, '0);
    rq = pair_req(341, 3, 5, 100, 0, 0);
    rq.grp_i = 1'b0;
    send_req(rq);
    rq = pair_req(341, 3, 5, 100, 0, 0);
    rq.grp_j = 1'b0;
    send_req(rq);
    rq = pair_req(341, 3, 5, 100, 0, 0);
    rq.same_mol = 1'b1;
    send_req(rq);
  endtask

  // forward, reverse, no match, outside and on the cutoff
  task automatic test_rule_directions();
    send_req(pair_req(682, 3, 5, 100, -200, 300));
    send_req(pair_req(682, 5, 3, -100, 200, 0));
    send_req(pair_req(682, 3, 3, 0, 0, 0));
    send_req(pair_req(682, 3, 5, 2049, 0, 0));
    send_req(pair_req(682, 3, 5, 0, -2048, 0));
  endtask

  // cosine taper inside the last sigma, and sigma as wide as the cutoff
  task automatic test_taper();
    drain();
    write_rules(2, pack_rule(1, 2, 4096, 4096, 1024), pack_rule(2, 1, -3000, 65535, 65535),
                '0, '0);
    send_req(pair_req(341, 1, 2, 3500, 0, 0));
    send_req(pair_req(341, 1, 2, 4096, 0, 0));
    send_req(pair_req(341, 2, 1, 0, 32767, -32768));
    send_req(pair_req(341, 1, 2, 3072, 0, 0));
  endtask

  // charge clamps at both ends; rule count above the slot count saturates
  task automatic test_saturation();
    drain();
    write_rules(7, pack_rule(4, 4, 32767, 8192, 0), pack_rule(4, 4, -32768, 8192, 0),
                pack_rule(6, 9, -32768, 8192, 0), pack_rule(9, 6, 32767, 8192, 0));
    send_req(pair_req(7, 6, 9, 10, 10, 10));
    send_req(pair_req(8, 9, 6, 10, 10, 10));
    send_req(pair_req(7, 4, 4, 1, 1, 1));
    send_req(pair_req(0, 9, 6, 0, 0, 0));
  endtask

  // hold the receiver off while requests keep coming
  task automatic test_backpressure();
    hold_rx = 1'b1;
    for (int k = 0; k < 6; k++) send_req(load_req($urandom_range(0, 1023), $urandom));
    drain();
  endtask

  function automatic int rand_delta(int span);
    int v;
    v = $urandom_range(0, span);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  // random rule set; extreme settings show up now and then
  task automatic randomize_rules(int phase);
    logic [CFG_DATA_W-1:0] w [WORD_COUNT];
    int rc, sg, cnt;
    for (int k = 0; k < WORD_COUNT; k++) begin
      rc = $urandom_range(256, 6000);
      case ($urandom_range(0, 5))
        0: sg = 0;
        1: sg = $urandom_range(rc, 65535);
        default: sg = $urandom_range(1, rc);
      endcase
      w[k] = pack_rule($urandom_range(0, 3), $urandom_range(0, 3), $urandom, rc, sg);
      if (phase % 7 == 3 && k == 0) w[k] = CFG_DATA_W'({$urandom, $urandom});
    end
    cnt = (phase % 5 == 0) ? 7 : (phase % 5 == 1) ? 0 : $urandom_range(1, 4);
    write_rules(cnt, w[0], w[1], w[2], w[3]);
  endtask

  // random traffic in phases with fresh rules, bursts and gaps
  task automatic test_random(int total);
    charge_req_t rq;
    int burst, span, pick;
    burst = 0;
    for (int n = 0; n < total; n++) begin
      if (n % 250 == 0) begin
        drain();
        randomize_rules(n / 250);
      end
      if (n == 700) begin
        drain();
        hold_rx = 1'b1;
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 3) == 0) idle_tx($urandom_range(1, 6));
      end
      burst--;
      pick = $urandom_range(0, 99);
      if (pick < 18 || loaded_atoms.size() == 0) begin
        rq = load_req($urandom_range(0, 1023), $urandom);
      end else begin
        span = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(64, 4000);
        rq = pair_req(loaded_atoms[$urandom_range(0, loaded_atoms.size() - 1)],
                      $urandom_range(0, 3), $urandom_range(0, 3),
                      rand_delta(span), rand_delta(span), rand_delta(span));
        if (pick >= 90) begin
          rq.ti       = TYPE_W'($urandom_range(0, 15));
          rq.tj       = TYPE_W'($urandom_range(0, 15));
          rq.grp_i    = 1'($urandom_range(0, 1));
          rq.grp_j    = 1'($urandom_range(0, 1));
          rq.same_mol = 1'($urandom_range(0, 1));
          rq.dx       = DELTA_W'($urandom);
          rq.dy       = DELTA_W'($urandom);
          rq.dz       = DELTA_W'($urandom);
        end
      end
      send_req(rq);
    end
  endtask

  // receiver: random stall modes, with a long hold when requested
  initial begin
    int mode, left;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 1) != 0);
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare each response against the oldest expectation
  always @(posedge clk) begin
    charge_rsp_t exp_rsp;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_charges.size() == 0) begin
        $display("%0t: unexpected response atom %0d charge %0d", $time,
                 out_if.atom_out, out_if.charge_out);
        fail_count++;
      end else begin
        exp_rsp = expected_charges.pop_front();
        if (out_if.atom_out !== exp_rsp.atom) begin
          $display("%0t: atom_out expected %0d actual %0d", $time, exp_rsp.atom,
                   out_if.atom_out);
          fail_count++;
        end
        if (out_if.charge_out !== exp_rsp.charge) begin
          $display("%0t: charge_out expected %0d actual %0d", $time, exp_rsp.charge,
                   out_if.charge_out);
          fail_count++;
        end
      end
    end
  end

  // reset, directed tests, random traffic, final verdict
  initial begin
    fail_count = 0;
    hold_rx    = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rule_cnt_model = '0;
    foreach (rule_word_model[k]) rule_word_model[k] = '0;
    foreach (loaded[k]) loaded[k] = 1'b0;
    in_if.valid         = 1'b0;
    in_if.op            = OP_LOAD;
    in_if.atom_index    = '0;
    in_if.charge_in     = '0;
    in_if.type_first    = '0;
    in_if.type_second   = '0;
    in_if.same_molecule = 1'b0;
    in_if.group_first   = 1'b0;
    in_if.group_second  = 1'b0;
    in_if.delta_x       = '0;
    in_if.delta_y       = '0;
    in_if.delta_z       = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_loads();
    test_skipped_pairs();
    test_rule_directions();
    test_taper();
    test_saturation();
    test_backpressure();
    test_random(1520);
    drain();

    if (fail_count == 0 && expected_charges.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
